// ----- rtl/core/hllg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Heun LLG spin update block.
// Depends on nothing; hllg_norm and heun_llg_spin_update use it by scoped names.
package hllg_pkg;

  typedef struct packed {
    logic               op;
    logic [11:0]        spin_index;
    logic signed [31:0] spin_x;
    logic signed [31:0] spin_y;
    logic signed [31:0] spin_z;
    logic signed [31:0] heff_x;
    logic signed [31:0] heff_y;
    logic signed [31:0] heff_z;
    logic [15:0]        damping;
    logic signed [31:0] gyro_factor;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
  } out_t;

  localparam logic OP_PREDICTOR = 1'b0;
  localparam logic OP_CORRECTOR = 1'b1;

  localparam logic [31:0] STEP_SIZE_RESET = 32'd4294967;

  // Width of the unnormalized updated spin and of its magnitude.
  localparam int UW = 40;
  localparam int MW = 39;
  // Bit position that the largest magnitude is brought to before the root.
  localparam logic [5:0] NORM_POS = 6'd30;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/hllg_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module hllg_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/hllg_norm.sv -----
`timescale 1ns / 1ps
// Pipelined normalization: magnitude scaling, sum of squares, integer square root
// and three restoring dividers. Depends on hllg_pkg.
module hllg_norm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [hllg_pkg::UW-1:0]    u [3],
  output logic                              out_valid,
  output hllg_pkg::out_t                    out_data
);

  localparam int MW = hllg_pkg::MW;

  // Front stages: magnitude, maximum, leading one, scaling, squares.
  logic          n1_v, n2_v, n3_v, n4_v, n5_v;
  logic [MW-1:0] n1_mag [3];
  logic [MW-1:0] n2_mag [3];
  logic [MW-1:0] n3_mag [3];
  logic          n1_neg [3];
  logic          n2_neg [3];
  logic          n3_neg [3];
  logic          n4_neg [3];
  logic          n5_neg [3];
  logic [MW-1:0] n2_m;
  logic [5:0]    n3_pos;
  logic          n3_zero, n4_zero, n5_zero;
  logic [30:0]   n4_nm [3];
  logic [30:0]   n5_nm [3];
  logic [61:0]   n5_sq [3];

  logic [5:0]    lead_pos;
  logic [MW-1:0] max_ab;
  logic [MW-1:0] shifted [3];

  // Square root pipeline: set 0 holds the radicand, set i+1 the result of bit pair i.
  logic        sq_v    [0:32];
  logic [63:0] sq_nsq  [0:32];
  logic [33:0] sq_rem  [0:32];
  logic [31:0] sq_root [0:32];
  logic [30:0] sq_nm   [0:32][3];
  logic        sq_neg  [0:32][3];
  logic        sq_zero [0:32];
  logic [33:0] sq_rem_next  [32];
  logic [31:0] sq_root_next [32];

  // Divider pipeline: set 0 holds the first partial remainder.
  logic        dv_v    [0:31];
  logic [31:0] dv_n    [0:31];
  logic [31:0] dv_rem  [0:31][3];
  logic [30:0] dv_nlo  [0:31][3];
  logic [30:0] dv_q    [0:31][3];
  logic        dv_neg  [0:31][3];
  logic        dv_zero [0:31];
  logic [31:0] dv_rem_next [31][3];
  logic [30:0] dv_q_next   [31][3];
  logic [61:0] numer [3];

  always_comb begin
    max_ab = (n1_mag[0] > n1_mag[1]) ? n1_mag[0] : n1_mag[1];
    lead_pos = '0;
    for (int b = 0; b < MW; b++) begin
      if (n2_m[b]) begin
        lead_pos = 6'(b);
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (n3_pos >= hllg_pkg::NORM_POS) begin
        shifted[k] = n3_mag[k] >> (n3_pos - hllg_pkg::NORM_POS);
      end else begin
        shifted[k] = n3_mag[k] << (hllg_pkg::NORM_POS - n3_pos);
      end
    end
  end

  // One result bit per stage of the digit-by-digit root.
  always_comb begin
    int j;
    logic [35:0] cur;
    logic [35:0] trial;
    for (int i = 0; i < 32; i++) begin
      j = 31 - i;
      cur = {sq_rem[i], sq_nsq[i][2*j +: 2]};
      trial = {2'b00, sq_root[i], 2'b01};
      if (cur >= trial) begin
        sq_rem_next[i] = 34'(cur - trial);
        sq_root_next[i] = {sq_root[i][30:0], 1'b1};
      end else begin
        sq_rem_next[i] = 34'(cur);
        sq_root_next[i] = {sq_root[i][30:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [32:0] cur;
    logic        ge;
    for (int k = 0; k < 3; k++) begin
      numer[k] = {1'b0, sq_nm[32][k], 30'd0} + 62'(sq_root[32] >> 1);
    end
    for (int i = 0; i < 31; i++) begin
      for (int k = 0; k < 3; k++) begin
        cur = {dv_rem[i][k], dv_nlo[i][k][30-i]};
        ge = cur >= {1'b0, dv_n[i]};
        dv_rem_next[i][k] = ge ? 32'(cur - {1'b0, dv_n[i]}) : 32'(cur);
        dv_q_next[i][k] = {dv_q[i][k][29:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_v <= 1'b0;
      n2_v <= 1'b0;
      n3_v <= 1'b0;
      n4_v <= 1'b0;
      n5_v <= 1'b0;
      for (int i = 0; i <= 32; i++) begin
        sq_v[i] <= 1'b0;
      end
      for (int i = 0; i < 32; i++) begin
        dv_v[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      n1_v <= in_valid;
      n2_v <= n1_v;
      n3_v <= n2_v;
      n4_v <= n3_v;
      n5_v <= n4_v;
      sq_v[0] <= n5_v;
      for (int i = 0; i < 32; i++) begin
        sq_v[i+1] <= sq_v[i];
      end
      dv_v[0] <= sq_v[32];
      for (int i = 0; i < 31; i++) begin
        dv_v[i+1] <= dv_v[i];
      end
      out_valid <= dv_v[31];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n1_neg[k] <= u[k] < 0;
        n1_mag[k] <= MW'((u[k] < 0) ? -u[k] : u[k]);
        n2_mag[k] <= n1_mag[k];
        n2_neg[k] <= n1_neg[k];
        n3_mag[k] <= n2_mag[k];
        n3_neg[k] <= n2_neg[k];
        n4_nm[k] <= shifted[k][30:0];
        n4_neg[k] <= n3_neg[k];
        n5_nm[k] <= n4_nm[k];
        n5_neg[k] <= n4_neg[k];
        n5_sq[k] <= n4_nm[k] * n4_nm[k];
      end
      n2_m <= (max_ab > n1_mag[2]) ? max_ab : n1_mag[2];
      n3_pos <= lead_pos;
      n3_zero <= n2_m == '0;
      n4_zero <= n3_zero;
      n5_zero <= n4_zero;

      sq_nsq[0] <= 64'(n5_sq[0]) + 64'(n5_sq[1]) + 64'(n5_sq[2]);
      sq_rem[0] <= '0;
      sq_root[0] <= '0;
      sq_zero[0] <= n5_zero;
      for (int k = 0; k < 3; k++) begin
        sq_nm[0][k] <= n5_nm[k];
        sq_neg[0][k] <= n5_neg[k];
      end
      for (int i = 0; i < 32; i++) begin
        sq_nsq[i+1] <= sq_nsq[i];
        sq_rem[i+1] <= sq_rem_next[i];
        sq_root[i+1] <= sq_root_next[i];
        sq_zero[i+1] <= sq_zero[i];
        for (int k = 0; k < 3; k++) begin
          sq_nm[i+1][k] <= sq_nm[i][k];
          sq_neg[i+1][k] <= sq_neg[i][k];
        end
      end

      dv_n[0] <= sq_root[32];
      dv_zero[0] <= sq_zero[32];
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= 32'(numer[k][61:31]);
        dv_nlo[0][k] <= numer[k][30:0];
        dv_q[0][k] <= '0;
        dv_neg[0][k] <= sq_neg[32][k];
      end
      for (int i = 0; i < 31; i++) begin
        dv_n[i+1] <= dv_n[i];
        dv_zero[i+1] <= dv_zero[i];
        for (int k = 0; k < 3; k++) begin
          dv_rem[i+1][k] <= dv_rem_next[i][k];
          dv_nlo[i+1][k] <= dv_nlo[i][k];
          dv_q[i+1][k] <= dv_q_next[i][k];
          dv_neg[i+1][k] <= dv_neg[i][k];
        end
      end

      if (dv_zero[31]) begin
        out_data <= '0;
      end else begin
        out_data.new_x <= dv_neg[31][0] ? -32'(dv_q[31][0]) : 32'(dv_q[31][0]);
        out_data.new_y <= dv_neg[31][1] ? -32'(dv_q[31][1]) : 32'(dv_q[31][1]);
        out_data.new_z <= dv_neg[31][2] ? -32'(dv_q[31][2]) : 32'(dv_q[31][2]);
      end
    end
  end

endmodule

// ----- rtl/core/heun_llg_spin_update.sv -----
`timescale 1ns / 1ps
// Heun predictor/corrector LLG spin update. One word is accepted every cycle
// unless the output buffer is full and not draining; each state RAM has a single
// read and a single write port and is read once and written at most once per word.
// A two-word output buffer keeps the pipeline moving while one result waits.
// Reset (rst, synchronous) clears valid bits and sets step_size to 4294967;
// the state RAMs are not cleared and hold undefined data until written.
module heun_llg_spin_update #(
  parameter int SPIN_COUNT = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  hllg_pkg::in_t   in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output hllg_pkg::out_t  out_item
);

  localparam int AW = (SPIN_COUNT > 1) ? $clog2(SPIN_COUNT) : 1;

  logic        en;
  logic [31:0] step_size;

  logic               v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;
  logic               op1, op2, op3, op4, op5, op6, op7, op8, op9, op10;
  logic [11:0]        idx1, idx2, idx3, idx4, idx5, idx6, idx7, idx8, idx9, idx10;
  logic               inr1, inr2, inr3, inr4, inr5, inr6, inr7, inr8, inr9, inr10;
  logic signed [31:0] s1_s [3];
  logic signed [31:0] s2_s [3];
  logic signed [31:0] s3_s [3];
  logic signed [31:0] s4_s [3];
  logic signed [31:0] s5_s [3];
  logic signed [31:0] s6_s [3];
  logic signed [31:0] s7_s [3];
  logic signed [31:0] s8_s [3];
  logic signed [31:0] s9_s [3];
  logic signed [31:0] s10_s [3];
  logic signed [31:0] s1_h [3];
  logic [15:0]        s1_a, s2_a, s3_a, s4_a, s5_a;
  logic signed [31:0] s1_g, s2_g, s3_g, s4_g, s5_g, s6_g, s7_g;
  logic signed [63:0] s2_p [6];
  logic signed [31:0] s3_c [3];
  logic signed [63:0] s4_p [6];
  logic signed [31:0] s4_c [3];
  logic signed [31:0] s5_c [3];
  logic signed [31:0] s5_sc [3];
  logic signed [31:0] s6_c [3];
  logic signed [48:0] s6_asc [3];
  logic signed [31:0] s7_t [3];
  logic signed [63:0] s8_gt [3];
  logic signed [31:0] s9_r [3];
  logic signed [31:0] s10_r [3];
  logic signed [31:0] s11_rate [3];
  logic signed [31:0] s11_base [3];
  logic signed [64:0] s12_prod [3];
  logic signed [31:0] s12_base [3];
  logic signed [hllg_pkg::UW-1:0] s13_u [3];

  logic signed [31:0] cross_c [3];
  logic signed [31:0] cross_sc [3];
  logic signed [31:0] t_val [3];
  logic signed [31:0] r_val [3];
  logic signed [31:0] rate [3];
  logic signed [31:0] base [3];
  logic signed [31:0] hr_read [3];
  logic signed [31:0] old_read [3];

  // State RAMs hold {x, y, z}; writes happen for the word in stage 10, reads are issued in stage 9.
  logic          old_we, half_we;
  logic [95:0]   old_rdata, half_rdata, old_wdata, half_wdata;
  logic [AW-1:0] raddr, waddr;

  logic        fwd_hit, fwd_pred;
  logic [95:0] fwd_old, fwd_half;

  logic                 norm_valid;
  hllg_pkg::out_t       norm_data;
  logic [1:0]           ob_cnt;
  hllg_pkg::out_t       ob_head, ob_tail;
  logic                 push, pop;

  assign cfg_ready = 1'b1;
  assign en = (ob_cnt != 2'd2) || out_ready;
  assign in_ready = en;
  assign out_valid = ob_cnt != 2'd0;
  assign out_item = ob_head;
  assign push = en && norm_valid;
  assign pop = out_valid && out_ready;

  assign raddr = AW'(idx9);
  assign waddr = AW'(idx10);

  always_comb begin
    logic signed [64:0] diff;
    logic signed [49:0] tsum;
    logic signed [64:0] ngt;
    for (int k = 0; k < 3; k++) begin
      diff = 65'(s2_p[2*k]) - 65'(s2_p[2*k+1]);
      cross_c[k] = hllg_pkg::sat32(66'(diff >>> 30));
      diff = 65'(s4_p[2*k]) - 65'(s4_p[2*k+1]);
      cross_sc[k] = hllg_pkg::sat32(66'(diff >>> 30));
      tsum = (50'(s6_c[k]) <<< 16) + 50'(s6_asc[k]);
      t_val[k] = hllg_pkg::sat32(66'(tsum >>> 16));
      ngt = -65'(s8_gt[k]);
      r_val[k] = hllg_pkg::sat32(66'(ngt >>> 16));
    end
  end

  // The word just ahead may have written this entry at the edge of the read.
  always_comb begin
    logic signed [31:0] half_r;
    logic signed [32:0] sum;
    for (int k = 0; k < 3; k++) begin
      hr_read[k] = '0;
      old_read[k] = '0;
      if (inr10) begin
        hr_read[k] = fwd_hit ? fwd_half[64-32*k +: 32] : half_rdata[64-32*k +: 32];
        old_read[k] = (fwd_hit && fwd_pred) ? fwd_old[64-32*k +: 32]
                                            : old_rdata[64-32*k +: 32];
      end
      half_r = s10_r[k] >>> 1;
      sum = 33'(hr_read[k]) + 33'(half_r);
      if (op10 == hllg_pkg::OP_CORRECTOR) begin
        rate[k] = hllg_pkg::sat32(66'(sum));
        base[k] = old_read[k];
        half_wdata[64-32*k +: 32] = rate[k];
      end else begin
        rate[k] = s10_r[k];
        base[k] = s10_s[k];
        half_wdata[64-32*k +: 32] = half_r;
      end
      old_wdata[64-32*k +: 32] = s10_s[k];
    end
  end

  assign half_we = en && v10 && inr10;
  assign old_we = half_we && (op10 == hllg_pkg::OP_PREDICTOR);

  hllg_ram #(.WIDTH(96), .DEPTH(SPIN_COUNT)) u_old_ram (
    .clk  (clk),
    .we   (old_we),
    .waddr(waddr),
    .wdata(old_wdata),
    .re   (en),
    .raddr(raddr),
    .rdata(old_rdata)
  );

  hllg_ram #(.WIDTH(96), .DEPTH(SPIN_COUNT)) u_half_ram (
    .clk  (clk),
    .we   (half_we),
    .waddr(waddr),
    .wdata(half_wdata),
    .re   (en),
    .raddr(raddr),
    .rdata(half_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= hllg_pkg::STEP_SIZE_RESET;
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13} <= '0;
      fwd_hit <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_size <= cfg_data;
      end
      if (en) begin
        v1 <= in_valid;
        {v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13} <=
          {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12};
        fwd_hit <= v10 && inr10 && (idx9 == idx10);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= in_item.op;
      idx1 <= in_item.spin_index;
      inr1 <= {20'd0, in_item.spin_index} < 32'(SPIN_COUNT);
      s1_s[0] <= in_item.spin_x;
      s1_s[1] <= in_item.spin_y;
      s1_s[2] <= in_item.spin_z;
      s1_h[0] <= in_item.heff_x;
      s1_h[1] <= in_item.heff_y;
      s1_h[2] <= in_item.heff_z;
      s1_a <= in_item.damping;
      s1_g <= in_item.gyro_factor;

      {op2, op3, op4, op5, op6, op7, op8, op9, op10} <=
        {op1, op2, op3, op4, op5, op6, op7, op8, op9};
      {idx2, idx3, idx4, idx5, idx6, idx7, idx8, idx9, idx10} <=
        {idx1, idx2, idx3, idx4, idx5, idx6, idx7, idx8, idx9};
      {inr2, inr3, inr4, inr5, inr6, inr7, inr8, inr9, inr10} <=
        {inr1, inr2, inr3, inr4, inr5, inr6, inr7, inr8, inr9};
      {s2_a, s3_a, s4_a, s5_a} <= {s1_a, s2_a, s3_a, s4_a};
      {s2_g, s3_g, s4_g, s5_g, s6_g, s7_g} <= {s1_g, s2_g, s3_g, s4_g, s5_g, s6_g};
      s2_s <= s1_s;
      s3_s <= s2_s;
      s4_s <= s3_s;
      s5_s <= s4_s;
      s6_s <= s5_s;
      s7_s <= s6_s;
      s8_s <= s7_s;
      s9_s <= s8_s;
      s10_s <= s9_s;

      s2_p[0] <= s1_s[1] * s1_h[2];
      s2_p[1] <= s1_s[2] * s1_h[1];
      s2_p[2] <= s1_s[2] * s1_h[0];
      s2_p[3] <= s1_s[0] * s1_h[2];
      s2_p[4] <= s1_s[0] * s1_h[1];
      s2_p[5] <= s1_s[1] * s1_h[0];
      s3_c <= cross_c;
      s4_p[0] <= s3_s[1] * s3_c[2];
      s4_p[1] <= s3_s[2] * s3_c[1];
      s4_p[2] <= s3_s[2] * s3_c[0];
      s4_p[3] <= s3_s[0] * s3_c[2];
      s4_p[4] <= s3_s[0] * s3_c[1];
      s4_p[5] <= s3_s[1] * s3_c[0];
      s4_c <= s3_c;
      s5_c <= s4_c;
      s5_sc <= cross_sc;
      s6_c <= s5_c;
      for (int k = 0; k < 3; k++) begin
        s6_asc[k] <= $signed({1'b0, s5_a}) * s5_sc[k];
        s8_gt[k] <= s7_g * s7_t[k];
        s12_prod[k] <= $signed({1'b0, step_size}) * s11_rate[k];
        s13_u[k] <= hllg_pkg::UW'(s12_base[k]) + hllg_pkg::UW'(s12_prod[k] >>> 26);
      end
      s7_t <= t_val;
      s9_r <= r_val;
      s10_r <= s9_r;
      s11_rate <= rate;
      s11_base <= base;
      s12_base <= s11_base;

      fwd_pred <= op10 == hllg_pkg::OP_PREDICTOR;
      fwd_old <= old_wdata;
      fwd_half <= half_wdata;
    end
  end

  hllg_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v13),
    .u        (s13_u),
    .out_valid(norm_valid),
    .out_data (norm_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_cnt <= 2'd0;
    end else begin
      case (ob_cnt)
        2'd0: begin
          if (push) begin
            ob_cnt <= 2'd1;
          end
        end
        2'd1: begin
          if (push && !pop) begin
            ob_cnt <= 2'd2;
          end else if (pop && !push) begin
            ob_cnt <= 2'd0;
          end
        end
        2'd2: begin
          if (pop && !push) begin
            ob_cnt <= 2'd1;
          end
        end
        default: ob_cnt <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ob_cnt == 2'd0 || (ob_cnt == 2'd1 && pop)) begin
      if (push) begin
        ob_head <= norm_data;
      end
    end else if (ob_cnt == 2'd1) begin
      if (push) begin
        ob_tail <= norm_data;
      end
    end else if (pop) begin
      ob_head <= ob_tail;
      if (push) begin
        ob_tail <= norm_data;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Input stalls only when the output buffer is full and not draining.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (ob_cnt == 2'd2) && !out_ready)
    else $error("input stalled without a full output buffer");

  // A forwarded entry always comes from a valid in-range write of the word ahead.
  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(en) && fwd_hit |-> $past(v10 && inr10))
    else $error("forward hit without a preceding write");

  // A result pushed into a full buffer must coincide with a pop.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && (ob_cnt == 2'd2) |-> pop)
    else $error("output buffer overflow");

  // The buffer never holds results that did not arrive.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (ob_cnt == 2'd0) && !push |=> ob_cnt == 2'd0)
    else $error("output buffer filled without a push");
`endif

endmodule

// ----- tb/sv/heun_llg_spin_update_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for heun_llg_spin_update: Heun predictor and corrector
// words are checked against a bit-exact fixed-point spin update model.
// Depends on hllg_pkg and the heun_llg_spin_update RTL.

class spin_scoreboard;
  hllg_pkg::out_t spin_q[$];
  int old_spin[4096][3];
  int half_rate[4096][3];
  bit [31:0] step;
  int errors;

  function new();
    step = hllg_pkg::STEP_SIZE_RESET;
    errors = 0;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit [63:0] root(bit [63:0] n);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic hllg_pkg::out_t unit_vector(longint u[3]);
    bit [63:0] mag[3], m, nsq, n, q;
    hllg_pkg::out_t o;
    logic [31:0] c[3];
    m = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (u[k] < 0) ? -u[k] : u[k];
      if (mag[k] > m) m = mag[k];
    end
    if (m == 0) return '0;
    while (m >= 64'h8000_0000) begin
      m = m >> 1;
      for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
    end
    while (m < 64'h4000_0000) begin
      m = m << 1;
      for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
    end
    nsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    n = root(nsq);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << 30) + (n >> 1)) / n;
      c[k] = 32'((u[k] < 0) ? (-q) : q);
    end
    o.new_x = c[0];
    o.new_y = c[1];
    o.new_z = c[2];
    return o;
  endfunction

  // Notes an accepted word: updates the spin store and queues the new spin.
  function void note_input(hllg_pkg::in_t it);
    longint s[3], h[3], c[3], sc[3], r[3], base[3], rate[3], u[3], t, alpha, g;
    int idx;
    idx = it.spin_index;
    s[0] = it.spin_x; s[1] = it.spin_y; s[2] = it.spin_z;
    h[0] = it.heff_x; h[1] = it.heff_y; h[2] = it.heff_z;
    alpha = {48'd0, it.damping};
    g = it.gyro_factor;
    for (int k = 0; k < 3; k++)
      c[k] = sat((s[(k+1)%3] * h[(k+2)%3] - s[(k+2)%3] * h[(k+1)%3]) >>> 30);
    for (int k = 0; k < 3; k++)
      sc[k] = sat((s[(k+1)%3] * c[(k+2)%3] - s[(k+2)%3] * c[(k+1)%3]) >>> 30);
    for (int k = 0; k < 3; k++) begin
      t = sat((c[k] * 65536 + alpha * sc[k]) >>> 16);
      r[k] = sat((-(g * t)) >>> 16);
    end
    for (int k = 0; k < 3; k++) begin
      if (it.op == hllg_pkg::OP_PREDICTOR) begin
        base[k] = s[k];
        rate[k] = r[k];
        old_spin[idx][k] = int'(s[k]);
        half_rate[idx][k] = int'(r[k] >>> 1);
      end else begin
        base[k] = old_spin[idx][k];
        rate[k] = sat(longint'(half_rate[idx][k]) + (r[k] >>> 1));
        half_rate[idx][k] = int'(rate[k]);
      end
      u[k] = base[k] + ((longint'({32'd0, step}) * rate[k]) >>> 26);
    end
    spin_q.push_back(unit_vector(u));
  endfunction

  function void check_result(hllg_pkg::out_t got);
    hllg_pkg::out_t want;
    if (spin_q.size() == 0) begin
      $display("%0t: unexpected word %h", $time, got);
      errors++;
      return;
    end
    want = spin_q.pop_front();
    if (got.new_x !== want.new_x) begin
      $display("%0t: new_x expected %h actual %h", $time, want.new_x, got.new_x);
      errors++;
    end
    if (got.new_y !== want.new_y) begin
      $display("%0t: new_y expected %h actual %h", $time, want.new_y, got.new_y);
      errors++;
    end
    if (got.new_z !== want.new_z) begin
      $display("%0t: new_z expected %h actual %h", $time, want.new_z, got.new_z);
      errors++;
    end
  endfunction

  function int pending();
    return spin_q.size();
  endfunction
endclass

module heun_llg_spin_update_test;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  hllg_pkg::in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hllg_pkg::out_t out_item;

  spin_scoreboard sb = new();
  bit written[4096];
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int cycles = 0;

  heun_llg_spin_update dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("heun_llg_spin_update_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_item);
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  task automatic send_word(hllg_pkg::in_t it);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    if (it.op == hllg_pkg::OP_PREDICTOR) written[it.spin_index] = 1'b1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_step(bit [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.step = v;
  endtask

  function automatic hllg_pkg::in_t make_word(logic op, logic [11:0] idx,
      logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, logic [31:0] hx,
      logic [31:0] hy, logic [31:0] hz, logic [15:0] damp, logic [31:0] g);
    hllg_pkg::in_t it;
    it.op = op; it.spin_index = idx;
    it.spin_x = sx; it.spin_y = sy; it.spin_z = sz;
    it.heff_x = hx; it.heff_y = hy; it.heff_z = hz;
    it.damping = damp; it.gyro_factor = g;
    return it;
  endfunction

  function automatic logic [31:0] rand_spin();
    if ($urandom_range(99) < 70) return $urandom_range(32'h8000_0000) - 32'h4000_0000;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_field();
    if ($urandom_range(99) < 60) return $urandom_range(32'h0200_0000) - 32'h0100_0000;
    return $urandom;
  endfunction

  function automatic hllg_pkg::in_t rand_word(logic op, logic [11:0] idx);
    logic [15:0] damp;
    logic [31:0] g;
    case ($urandom_range(9))
      0: damp = 16'h0000;
      1: damp = 16'hFFFF;
      default: damp = 16'($urandom);
    endcase
    g = ($urandom_range(99) < 75) ? ($urandom_range(32'h0800_0000) - 32'h0400_0000)
                                  : $urandom;
    return make_word(op, idx, rand_spin(), rand_spin(), rand_spin(),
                     rand_field(), rand_field(), rand_field(), damp, g);
  endfunction

  // One Heun step over a handful of spins, with occasional noise words.
  task automatic heun_group();
    logic [11:0] idx[$];
    int n;
    logic [11:0] v;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      v = ($urandom_range(1) == 0) ? 12'($urandom_range(15)) : 12'($urandom_range(4095));
      idx.push_back(v);
      send_word(rand_word(hllg_pkg::OP_PREDICTOR, v));
    end
    foreach (idx[i]) begin
      send_word(rand_word(hllg_pkg::OP_CORRECTOR, idx[i]));
      if ($urandom_range(9) == 0) send_word(rand_word(hllg_pkg::OP_CORRECTOR, idx[i]));
    end
    if ($urandom_range(4) == 0) begin
      v = 12'($urandom_range(4095));
      if (written[v]) send_word(rand_word(hllg_pkg::OP_CORRECTOR, v));
      else send_word(rand_word(hllg_pkg::OP_PREDICTOR, v));
    end
  endtask

  initial begin
    bit [31:0] steps[6];
    int sent;
    steps[0] = 32'h0000_0000;
    steps[1] = 32'hFFFF_FFFF;
    steps[2] = hllg_pkg::STEP_SIZE_RESET;
    steps[3] = $urandom;
    steps[4] = 32'h1000_0000;
    steps[5] = $urandom_range(32'h0100_0000);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset step size.
    send_word(make_word(hllg_pkg::OP_PREDICTOR, 12'd0, 32'h4000_0000, 0, 0,
                        0, 0, 32'h0001_0000, 16'h1000, 32'h0100_0000));
    send_word(make_word(hllg_pkg::OP_CORRECTOR, 12'd0, 32'h3FFF_0000, 32'h0100_0000, 0,
                        0, 0, 32'h0001_0000, 16'h1000, 32'h0100_0000));
    send_word(make_word(hllg_pkg::OP_CORRECTOR, 12'd0, 32'h3FFF_0000, 32'h0100_0000, 0,
                        0, 0, 32'h0001_0000, 16'h1000, 32'h0100_0000));
    send_word(make_word(hllg_pkg::OP_PREDICTOR, 12'hFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        16'hFFFF, 32'h8000_0000));
    send_word(make_word(hllg_pkg::OP_CORRECTOR, 12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        16'hFFFF, 32'h7FFF_FFFF));
    // A zero spin has zero rate and normalizes to the zero vector.
    send_word(make_word(hllg_pkg::OP_PREDICTOR, 12'd1, 0, 0, 0, 32'h7FFF_FFFF,
                        32'h1234_5678, 32'h8000_0000, 16'hFFFF, 32'h7FFF_FFFF));
    send_word(make_word(hllg_pkg::OP_CORRECTOR, 12'd1, 0, 0, 0, 32'h0001_0000,
                        0, 0, 16'h8000, 32'h0100_0000));
    send_word(make_word(hllg_pkg::OP_PREDICTOR, 12'd2, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        16'h0000, 32'h0000_0000));
    send_word(make_word(hllg_pkg::OP_PREDICTOR, 12'hAAA, 32'h2000_0000, 32'hE000_0000,
                        32'h2D41_3CCD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                        16'hFFFF, 32'h8000_0000));
    send_word(make_word(hllg_pkg::OP_PREDICTOR, 12'h555, 32'h0000_0001, 32'hFFFF_FFFF,
                        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                        16'h0001, 32'h7FFF_FFFF));
    send_word(make_word(hllg_pkg::OP_CORRECTOR, 12'hAAA, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        16'hFFFF, 32'h8000_0000));
    send_word(make_word(hllg_pkg::OP_CORRECTOR, 12'h555, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        16'hFFFF, 32'h7FFF_FFFF));
    send_word(make_word(hllg_pkg::OP_CORRECTOR, 12'd2, 32'h4000_0000, 0, 0,
                        0, 32'h0100_0000, 0, 16'h4000, 32'hF000_0000));
    drain();

    foreach (steps[p]) begin
      write_step(steps[p]);
      calm = (p == 2);
      sent = 0;
      while (sent < 210) begin
        if (p == 2 && sent >= 40 && sent < 48) hold_req = 1'b1;
        heun_group();
        sent = sent + 10;
      end
      calm = 1'b0;
      drain();
    end

    if (sb.errors == 0) begin
      $display("heun_llg_spin_update_test: done, clean");
    end else begin
      $display("heun_llg_spin_update_test: done, errors");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/hllg_pkg.sv
rtl/core/hllg_ram.sv
rtl/core/hllg_norm.sv
rtl/core/heun_llg_spin_update.sv
tb/sv/heun_llg_spin_update_test.sv
